/* rtl/core/htw_pkg.sv */
// ----------------------------------------------------------------------------
// htw_pkg: shared types and constants of the hashed timing wheel
// Sizes of the timer pool and wheel, operation and status codes, and the
// sequencer states.
// ----------------------------------------------------------------------------
package htw_pkg;

  // Wheel and pool sizes. The slot arithmetic wraps at a power of two.
  localparam int SLOTS  = 64;
  localparam int TIMERS = 64;
  localparam int SLOT_W = 6;
  localparam int H_W    = 6;
  localparam int LINK_W = 7;
  localparam int ROT_W  = 25;
  localparam int TMO_W  = 31;
  localparam int INT_W  = 16;

  // Null link value.
  localparam logic [LINK_W-1:0] NIL = 7'd127;

  // Operation codes.
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_ADJ  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EXP   = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_BAD   = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_ARM_RD,
    S_ARM_WR1,
    S_ARM_WR2,
    S_UNL_RD,
    S_UNL_HD,
    S_UNL_WR,
    S_FIN,
    S_TK_HEAD,
    S_TK_CHK,
    S_TK_NEXT,
    S_TK_EVAL,
    S_TK_PUSH,
    S_TK_END
  } state_t;

  // A link names a timer when its top bit is clear.
  function automatic logic is_link(input logic [LINK_W-1:0] x);
    return !x[LINK_W-1];
  endfunction

endpackage

/* rtl/core/htw_in_if.sv */
// ----------------------------------------------------------------------------
// htw_in_if: request channel of the timing wheel
// Carries one operation per transfer.
// ----------------------------------------------------------------------------
interface htw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [5:0]  handle;
  logic [30:0] timeout;

  modport source (output valid, output op, output handle, output timeout, input ready);
  modport sink   (input valid, input op, input handle, input timeout, output ready);
endinterface

/* rtl/core/htw_out_if.sv */
// ----------------------------------------------------------------------------
// htw_out_if: result channel of the timing wheel
// Carries one result per transfer.
// ----------------------------------------------------------------------------
interface htw_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] expired_handle;
  logic [5:0] slot_now;
  logic       last;

  modport source (output valid, output status, output expired_handle, output slot_now,
                  output last, input ready);
  modport sink   (input valid, input status, input expired_handle, input slot_now,
                  input last, output ready);
endinterface

/* rtl/core/htw_ram.sv */
// ----------------------------------------------------------------------------
// htw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module htw_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/htw_div.sv */
// ----------------------------------------------------------------------------
// htw_div: radix-2 restoring divider
// Divides a 31-bit timeout by the 16-bit slot interval, one quotient bit per
// cycle. The quotient stays on its output until the next start.
// ----------------------------------------------------------------------------
module htw_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [htw_pkg::TMO_W-1:0]  dividend,
  input  logic [htw_pkg::INT_W-1:0]  divisor,
  output logic                       done,
  output logic [htw_pkg::TMO_W-1:0]  quot
);

  logic [htw_pkg::TMO_W-1:0] q_r, q_nxt;
  logic [htw_pkg::INT_W:0]   rem_r, rem_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [htw_pkg::INT_W:0]   rem_sh;

  // One restoring step per cycle.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[htw_pkg::INT_W-1:0], q_r[htw_pkg::TMO_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = rem_sh - {1'b0, divisor};
        q_nxt   = {q_r[htw_pkg::TMO_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[htw_pkg::TMO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(htw_pkg::TMO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* rtl/core/hashed_timing_wheel.sv */
// ----------------------------------------------------------------------------
// hashed_timing_wheel: 64-slot hashed timing wheel over 64 timer handles
// Add, re-arm and delete timers by handle and advance the wheel by ticks.
// ----------------------------------------------------------------------------
// One request is handled at a time; the block is not ready while it works.
// Add and re-arm both wait on the 31-step shared divider that turns the
// timeout into wheel ticks; delete needs no division. A tick walks the slot
// list through RAMs with registered reads, counting down each timer that
// still has rotations to go and unlinking each timer that expires. Expired
// timers come out in list order, one result per transfer, the final one
// marked by last. No clearing pass is needed after reset.
module hashed_timing_wheel (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  htw_in_if.sink       in_ch,
  htw_out_if.source    out_ch
);

  localparam int LW = htw_pkg::LINK_W;
  localparam int HW = htw_pkg::H_W;
  localparam int SW = htw_pkg::SLOT_W;

  htw_pkg::state_t state_r, state_nxt;

  logic [1:0]              op_r;
  logic [HW-1:0]           h_r;
  logic [SW-1:0]           sn_r;
  logic [1:0]              stat_r;
  logic [LW-1:0]           cur_r;
  logic [LW-1:0]           nxt_r;
  logic [LW-1:0]           prev_r;
  logic [SW-1:0]           slot_r;
  logic [htw_pkg::TMO_W-1:0] tmo_r;
  logic                    pend_valid_r;
  logic [HW-1:0]           pend_h_r;
  logic [SW-1:0]           cur_slot_r;
  logic [htw_pkg::INT_W-1:0] si_r;
  logic [htw_pkg::TIMERS-1:0] entry_valid_r;
  logic [htw_pkg::SLOTS-1:0]  head_valid_r;
  logic                    hv_q_r;

  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic [HW-1:0]           out_handle_r;
  logic [SW-1:0]           out_slot_r;
  logic                    out_last_r;

  // RAM ports
  logic                    head_we;
  logic [SW-1:0]           head_waddr, head_raddr;
  logic [LW-1:0]           head_wdata, head_rdata;
  logic                    next_we, prev_we, rot_we, slot_we, tmo_we;
  logic [HW-1:0]           next_waddr, prev_waddr, rot_waddr;
  logic [LW-1:0]           next_wdata, prev_wdata, next_rdata, prev_rdata;
  logic [htw_pkg::ROT_W-1:0] rot_wdata, rot_rdata;
  logic [SW-1:0]           slot_rdata;
  logic [htw_pkg::TMO_W-1:0] tmo_rdata;
  logic [HW-1:0]           ent_raddr;

  // Divider ports
  logic                    div_start, div_done;
  logic [htw_pkg::TMO_W-1:0] div_dividend, div_q;
  logic [htw_pkg::INT_W-1:0] si_eff;

  logic                    accept, out_free, unl_is_head;
  logic [LW-1:0]           head_now;
  logic [htw_pkg::TMO_W-1:0] ticks;
  logic [SW-1:0]           arm_slot;

  // Common terms.
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign head_now    = hv_q_r ? head_rdata : htw_pkg::NIL;
  assign ent_raddr   = (op_r == htw_pkg::OP_TICK) ? cur_r[HW-1:0] : h_r;
  assign unl_is_head = (head_now == {1'b0, ent_raddr});
  assign ticks       = (div_q == '0) ? htw_pkg::TMO_W'(1) : div_q;
  assign arm_slot    = cur_slot_r + ticks[SW-1:0];
  assign si_eff      = (si_r == '0) ? htw_pkg::INT_W'(1) : si_r;
  assign in_ch.ready = (state_r == htw_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      htw_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_ch.op)
            htw_pkg::OP_ADD:
              state_nxt = entry_valid_r[in_ch.handle] ? htw_pkg::S_FIN : htw_pkg::S_DIV;
            htw_pkg::OP_ADJ, htw_pkg::OP_DEL:
              state_nxt = entry_valid_r[in_ch.handle] ? htw_pkg::S_UNL_RD : htw_pkg::S_FIN;
            default: state_nxt = htw_pkg::S_TK_HEAD;
          endcase
        end
      end
      htw_pkg::S_DIV:     if (div_done) state_nxt = htw_pkg::S_ARM_RD;
      htw_pkg::S_ARM_RD:  state_nxt = htw_pkg::S_ARM_WR1;
      htw_pkg::S_ARM_WR1: state_nxt = htw_pkg::S_ARM_WR2;
      htw_pkg::S_ARM_WR2: state_nxt = htw_pkg::S_FIN;
      htw_pkg::S_UNL_RD:  state_nxt = htw_pkg::S_UNL_HD;
      htw_pkg::S_UNL_HD:  state_nxt = htw_pkg::S_UNL_WR;
      htw_pkg::S_UNL_WR: begin
        unique case (op_r)
          htw_pkg::OP_ADJ:  state_nxt = htw_pkg::S_DIV;
          htw_pkg::OP_TICK: state_nxt = htw_pkg::S_TK_PUSH;
          default:          state_nxt = htw_pkg::S_FIN;
        endcase
      end
      htw_pkg::S_FIN:     if (out_free) state_nxt = htw_pkg::S_IDLE;
      htw_pkg::S_TK_HEAD: state_nxt = htw_pkg::S_TK_CHK;
      htw_pkg::S_TK_CHK:  state_nxt = htw_pkg::S_TK_NEXT;
      htw_pkg::S_TK_NEXT:
        state_nxt = htw_pkg::is_link(cur_r) ? htw_pkg::S_TK_EVAL : htw_pkg::S_TK_END;
      htw_pkg::S_TK_EVAL:
        state_nxt = (rot_rdata != '0) ? htw_pkg::S_TK_NEXT : htw_pkg::S_UNL_RD;
      htw_pkg::S_TK_PUSH:
        if (!pend_valid_r || out_free) state_nxt = htw_pkg::S_TK_NEXT;
      htw_pkg::S_TK_END:  if (out_free) state_nxt = htw_pkg::S_IDLE;
      default:            state_nxt = htw_pkg::S_IDLE;
    endcase
  end

  // RAM and divider controls for each state.
  always_comb begin
    head_we      = 1'b0;
    head_waddr   = slot_r;
    head_wdata   = nxt_r;
    head_raddr   = cur_slot_r;
    next_we      = 1'b0;
    next_waddr   = prev_r[HW-1:0];
    next_wdata   = nxt_r;
    prev_we      = 1'b0;
    prev_waddr   = nxt_r[HW-1:0];
    prev_wdata   = prev_r;
    rot_we       = 1'b0;
    rot_waddr    = h_r;
    rot_wdata    = ticks[htw_pkg::TMO_W-1:SW];
    slot_we      = 1'b0;
    tmo_we       = 1'b0;
    div_start    = 1'b0;
    div_dividend = tmo_r;
    unique case (state_r)
      htw_pkg::S_IDLE: begin
        if (accept && in_ch.op == htw_pkg::OP_ADD && !entry_valid_r[in_ch.handle]) begin
          tmo_we       = 1'b1;
          div_start    = 1'b1;
          div_dividend = in_ch.timeout;
        end
      end
      htw_pkg::S_ARM_RD: head_raddr = arm_slot;
      htw_pkg::S_ARM_WR1: begin
        // Insert at the head of the target slot.
        rot_we     = 1'b1;
        slot_we    = 1'b1;
        next_we    = 1'b1;
        next_waddr = h_r;
        next_wdata = head_now;
        prev_we    = 1'b1;
        prev_waddr = h_r;
        prev_wdata = htw_pkg::NIL;
        head_we    = 1'b1;
        head_wdata = {1'b0, h_r};
      end
      htw_pkg::S_ARM_WR2: begin
        prev_we    = htw_pkg::is_link(nxt_r);
        prev_wdata = {1'b0, h_r};
      end
      htw_pkg::S_UNL_HD: head_raddr = slot_rdata;
      htw_pkg::S_UNL_WR: begin
        // Bridge the neighbors of the removed timer.
        if (unl_is_head) begin
          head_we    = 1'b1;
          prev_we    = htw_pkg::is_link(nxt_r);
          prev_wdata = htw_pkg::NIL;
        end else begin
          next_we = htw_pkg::is_link(prev_r);
          prev_we = htw_pkg::is_link(nxt_r);
        end
        div_start = (op_r == htw_pkg::OP_ADJ);
      end
      htw_pkg::S_TK_EVAL: begin
        // Count down a timer that still has rotations to go.
        rot_we    = (rot_rdata != '0);
        rot_waddr = cur_r[HW-1:0];
        rot_wdata = rot_rdata - htw_pkg::ROT_W'(1);
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= htw_pkg::S_IDLE;
      si_r          <= htw_pkg::INT_W'(1);
      cur_slot_r    <= '0;
      entry_valid_r <= '0;
      head_valid_r  <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        si_r <= cfg_wdata;
      end
      if (head_we) begin
        head_valid_r[head_waddr] <= 1'b1;
      end
      if (state_r == htw_pkg::S_IDLE && accept && in_ch.op == htw_pkg::OP_ADD) begin
        entry_valid_r[in_ch.handle] <= 1'b1;
      end
      if (state_r == htw_pkg::S_UNL_WR && op_r != htw_pkg::OP_ADJ) begin
        entry_valid_r[ent_raddr] <= 1'b0;
      end
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == htw_pkg::S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end
      // A held expiry is sent on once the result register is free; the new
      // one always takes its place.
      if (state_r == htw_pkg::S_TK_PUSH && (!pend_valid_r || out_free)) begin
        if (pend_valid_r) begin
          out_valid_r <= 1'b1;
        end
        pend_valid_r <= 1'b1;
      end
      if (state_r == htw_pkg::S_TK_END && out_free) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
        cur_slot_r   <= cur_slot_r + SW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hv_q_r <= head_valid_r[head_raddr];
    unique case (state_r)
      htw_pkg::S_IDLE: begin
        op_r   <= in_ch.op;
        h_r    <= in_ch.handle;
        sn_r   <= cur_slot_r;
        stat_r <= (in_ch.op == htw_pkg::OP_ADD) ?
                  (entry_valid_r[in_ch.handle] ? htw_pkg::STAT_BAD : htw_pkg::STAT_DONE) :
                  (entry_valid_r[in_ch.handle] ? htw_pkg::STAT_DONE : htw_pkg::STAT_BAD);
      end
      htw_pkg::S_ARM_RD:  slot_r <= arm_slot;
      htw_pkg::S_ARM_WR1: nxt_r  <= head_now;
      htw_pkg::S_UNL_HD: begin
        slot_r <= slot_rdata;
        nxt_r  <= next_rdata;
        prev_r <= prev_rdata;
        tmo_r  <= tmo_rdata;
      end
      htw_pkg::S_TK_CHK:  cur_r <= head_now;
      htw_pkg::S_TK_EVAL: if (rot_rdata != '0) cur_r <= next_rdata;
      htw_pkg::S_TK_PUSH: begin
        if (!pend_valid_r || out_free) begin
          pend_h_r <= cur_r[HW-1:0];
          cur_r    <= nxt_r;
        end
      end
      default: ;
    endcase

    // Result register loads.
    if (state_r == htw_pkg::S_FIN && out_free) begin
      out_status_r <= stat_r;
      out_handle_r <= h_r;
      out_slot_r   <= sn_r;
      out_last_r   <= 1'b1;
    end else if (state_r == htw_pkg::S_TK_PUSH && out_free && pend_valid_r) begin
      out_status_r <= htw_pkg::STAT_EXP;
      out_handle_r <= pend_h_r;
      out_slot_r   <= sn_r;
      out_last_r   <= 1'b0;
    end else if (state_r == htw_pkg::S_TK_END && out_free) begin
      out_status_r <= pend_valid_r ? htw_pkg::STAT_EXP : htw_pkg::STAT_EMPTY;
      out_handle_r <= pend_valid_r ? pend_h_r : h_r;
      out_slot_r   <= sn_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.expired_handle = out_handle_r;
  assign out_ch.slot_now       = out_slot_r;
  assign out_ch.last           = out_last_r;

  // Shared divider.
  htw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (si_eff),
    .done     (div_done),
    .quot     (div_q)
  );

  // Slot heads and per-timer fields.
  htw_ram #(.W(LW), .D(htw_pkg::SLOTS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  htw_ram #(.W(LW), .D(htw_pkg::TIMERS)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(ent_raddr), .rdata(next_rdata)
  );

  htw_ram #(.W(LW), .D(htw_pkg::TIMERS)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(ent_raddr), .rdata(prev_rdata)
  );

  htw_ram #(.W(htw_pkg::ROT_W), .D(htw_pkg::TIMERS)) u_rot (
    .clk(clk), .we(rot_we), .waddr(rot_waddr), .wdata(rot_wdata),
    .raddr(ent_raddr), .rdata(rot_rdata)
  );

  htw_ram #(.W(SW), .D(htw_pkg::TIMERS)) u_slot (
    .clk(clk), .we(slot_we), .waddr(h_r), .wdata(slot_r),
    .raddr(ent_raddr), .rdata(slot_rdata)
  );

  htw_ram #(.W(htw_pkg::TMO_W), .D(htw_pkg::TIMERS)) u_tmo (
    .clk(clk), .we(tmo_we), .waddr(in_ch.handle), .wdata(in_ch.timeout),
    .raddr(ent_raddr), .rdata(tmo_rdata)
  );

`ifndef SYNTH
  // The divider finishes only while the sequencer waits on it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == htw_pkg::S_DIV)
    else $error("divider finished outside the divide state");

  // A held expiry belongs to a tick in progress.
  a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> op_r == htw_pkg::OP_TICK)
    else $error("pending expiry outside a tick");

  // Ending a tick advances the wheel by exactly one slot.
  a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == htw_pkg::S_TK_END && out_free) |=>
      cur_slot_r == $past(cur_slot_r) + SW'(1))
    else $error("wheel did not advance by one slot");
`endif

endmodule
